// File: rtl/yuyv_to_rgb_converter_core_assert.svh
// Assertion macros used by the checker file of the converter.
`ifndef YUYV_TO_RGB_CONVERTER_CORE_ASSERT_SVH
`define YUYV_TO_RGB_CONVERTER_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define YUYV_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define YUYV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/yuyv2rgb_pkg.sv
// Types, constants and arithmetic helpers for the YUYV to RGB converter.
package yuyv2rgb_pkg;

    localparam int PIX_W       = 8;
    localparam int PROD_W      = 19;
    localparam int TERM_W      = 11;
    localparam int SUM_W       = 13;
    localparam int SCALE_SHIFT = 8;

    typedef logic [PIX_W-1:0]         pixel_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic signed [TERM_W-1:0] term_t;
    typedef logic signed [SUM_W-1:0]  sum_t;

    localparam prod_t LUMA_OFFSET   = 19'sd16;
    localparam prod_t CHROMA_OFFSET = 19'sd128;
    localparam prod_t LUMA_GAIN     = 19'sd298;
    localparam prod_t CR_TO_R       = 19'sd459;
    localparam prod_t CB_TO_B       = 19'sd541;
    localparam prod_t CB_TO_G       = -19'sd137;
    localparam prod_t CR_TO_G       = -19'sd55;
    localparam prod_t ROUND_BIAS    = prod_t'((1 << SCALE_SHIFT) - 1);
    localparam sum_t  BYTE_MAX      = sum_t'((1 << PIX_W) - 1);

    typedef struct packed {
        term_t r_add;
        term_t gu_add;
        term_t gv_add;
        term_t b_add;
    } chroma_terms_t;

    typedef struct packed {
        logic load_s1;
        logic load_s2;
    } stage_ctrl_t;

    // Divide by 256 with truncation toward zero.
    function automatic term_t scale_term(prod_t p);
        prod_t biased;
        biased = p + (p[PROD_W-1] ? ROUND_BIAS : prod_t'(0));
        return term_t'(biased >>> SCALE_SHIFT);
    endfunction

    function automatic prod_t widen(pixel_t c);
        return prod_t'({1'b0, c});
    endfunction

    function automatic pixel_t clamp_byte(sum_t s);
        pixel_t res;
        if (s < 0)
            res = '0;
        else if (s > BYTE_MAX)
            res = '1;
        else
            res = s[PIX_W-1:0];
        return res;
    endfunction

endpackage

// File: rtl/yuyv_to_rgb_converter_core.sv
// YUYV 4:2:2 macropixel to two RGB pixels, integer coefficients.
//
// Input channel: in_valid / in_stall with luma_first, chroma_blue,
// luma_second and chroma_red, one packed macropixel per transaction.
// Output channel: out_valid / out_stall with the clamped RGB bytes of
// both pixels, one transaction per input transaction, in order.
// An accepted macropixel is registered in stage 1 and then in the output
// registers, where out_valid rises; a held output result can delay the move.
// Throughput: one macropixel per cycle while the output is not stalled, through the two register stages
// (multiply and divide, then merge and clamp).
// Two luma lanes run side by side and share one chroma unit.
// When out_stall holds a waiting result, the first stage still takes one
// more transaction; in_stall rises only when both stages are full.
// Reset clears both stage valid flags; no result is shown until new
// input arrives. The block keeps no state between transactions.
module yuyv_to_rgb_converter_core
    import yuyv2rgb_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_stall,
    input  pixel_t luma_first,
    input  pixel_t chroma_blue,
    input  pixel_t luma_second,
    input  pixel_t chroma_red,
    output logic   out_valid,
    input  logic   out_stall,
    output pixel_t red_first,
    output pixel_t green_first,
    output pixel_t blue_first,
    output pixel_t red_second,
    output pixel_t green_second,
    output pixel_t blue_second
);

    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          s2_open;
    stage_ctrl_t   ctrl;
    chroma_terms_t terms;

    always_comb
    begin
        s2_open        = !(out_valid_reg && out_stall);
        in_stall       = s1_valid_reg && !s2_open;
        ctrl.load_s1   = in_valid && !in_stall;
        ctrl.load_s2   = s2_open && s1_valid_reg;
        s1_valid_next  = ctrl.load_s1 ? 1'b1 : (s2_open ? 1'b0 : s1_valid_reg);
        out_valid_next = s2_open ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    yuyv2rgb_chroma u_chroma (
        .clk         (clk),
        .load        (ctrl.load_s1),
        .chroma_blue (chroma_blue),
        .chroma_red  (chroma_red),
        .terms       (terms)
    );

    yuyv2rgb_lane u_lane_first (
        .clk   (clk),
        .ctrl  (ctrl),
        .luma  (luma_first),
        .terms (terms),
        .red   (red_first),
        .green (green_first),
        .blue  (blue_first)
    );

    yuyv2rgb_lane u_lane_second (
        .clk   (clk),
        .ctrl  (ctrl),
        .luma  (luma_second),
        .terms (terms),
        .red   (red_second),
        .green (green_second),
        .blue  (blue_second)
    );

endmodule

// File: rtl/yuyv2rgb_chroma.sv
// Shared chroma unit: scaled chroma contributions for both pixel lanes.
module yuyv2rgb_chroma
    import yuyv2rgb_pkg::*;
(
    input  logic          clk,
    input  logic          load,
    input  pixel_t        chroma_blue,
    input  pixel_t        chroma_red,
    output chroma_terms_t terms
);

    prod_t         du;
    prod_t         dv;
    prod_t         r_prod;
    prod_t         gu_prod;
    prod_t         gv_prod;
    prod_t         b_prod;
    chroma_terms_t terms_next;
    chroma_terms_t terms_reg;

    always_comb
    begin
        du      = widen(chroma_blue) - CHROMA_OFFSET;
        dv      = widen(chroma_red) - CHROMA_OFFSET;
        r_prod  = CR_TO_R * dv;
        gu_prod = CB_TO_G * du;
        gv_prod = CR_TO_G * dv;
        b_prod  = CB_TO_B * du;
        terms_next.r_add  = scale_term(r_prod);
        terms_next.gu_add = scale_term(gu_prod);
        terms_next.gv_add = scale_term(gv_prod);
        terms_next.b_add  = scale_term(b_prod);
    end

    always_ff @(posedge clk)
    begin
        if (load)
            terms_reg <= terms_next;
    end

    assign terms = terms_reg;

endmodule

// File: rtl/yuyv2rgb_lane.sv
// One pixel lane: luma scaling, then chroma merge and clamp into the output register.
module yuyv2rgb_lane
    import yuyv2rgb_pkg::*;
(
    input  logic          clk,
    input  stage_ctrl_t   ctrl,
    input  pixel_t        luma,
    input  chroma_terms_t terms,
    output pixel_t        red,
    output pixel_t        green,
    output pixel_t        blue
);

    prod_t  l_prod;
    term_t  luma_term_next;
    term_t  luma_term_reg;
    sum_t   r_sum;
    sum_t   g_sum;
    sum_t   b_sum;
    pixel_t red_next;
    pixel_t green_next;
    pixel_t blue_next;
    pixel_t red_reg;
    pixel_t green_reg;
    pixel_t blue_reg;

    always_comb
    begin
        l_prod         = LUMA_GAIN * (widen(luma) - LUMA_OFFSET);
        luma_term_next = scale_term(l_prod);
    end

    always_comb
    begin
        r_sum = sum_t'(luma_term_reg) + sum_t'(terms.r_add);
        g_sum = sum_t'(luma_term_reg) + sum_t'(terms.gu_add) + sum_t'(terms.gv_add);
        b_sum = sum_t'(luma_term_reg) + sum_t'(terms.b_add);
        red_next   = clamp_byte(r_sum);
        green_next = clamp_byte(g_sum);
        blue_next  = clamp_byte(b_sum);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load_s1)
            luma_term_reg <= luma_term_next;
        if (ctrl.load_s2)
        begin
            red_reg   <= red_next;
            green_reg <= green_next;
            blue_reg  <= blue_next;
        end
    end

    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

// File: rtl/yuyv2rgb_checker.sv
// Port-level checker for the converter, bound to the top level.
`include "yuyv_to_rgb_converter_core_assert.svh"

module yuyv2rgb_checker
    import yuyv2rgb_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   in_valid,
    input logic   in_stall,
    input pixel_t luma_first,
    input pixel_t chroma_blue,
    input pixel_t luma_second,
    input pixel_t chroma_red,
    input logic   out_valid,
    input logic   out_stall,
    input pixel_t red_first,
    input pixel_t green_first,
    input pixel_t blue_first,
    input pixel_t red_second,
    input pixel_t green_second,
    input pixel_t blue_second
);

    // Back-pressure on the input only when a result is held at the output.
    `YUYV_ASSERT_SAME(a_stall_source, in_stall, out_valid && out_stall, "in_stall without held output")

    // An accepted transaction passes stage 1 and then reaches the output if not stalled.
    `YUYV_ASSERT_NEXT(a_latency, (in_valid && !in_stall) ##1 !out_stall, out_valid, "result missing after two cycles")

    `YUYV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "out_valid dropped under stall")

    `YUYV_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(red_first) && $stable(green_first) && $stable(blue_first) && $stable(red_second) && $stable(green_second) && $stable(blue_second), "payload changed under stall")

endmodule

bind yuyv_to_rgb_converter_core yuyv2rgb_checker u_checker (.*);
